// File: src/bounded_deque_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Bounded deque engine: assertion macros
// Shared property forms for the checker of the deque engine.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define BDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define BDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine package
// Widths, request codes, cell control and tree sizing shared by the design, checker and testbench files.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int CAP_W     = 7;
    localparam int OCC_W     = 7;
    localparam int DEPTH_DEF = 64;
    localparam int FAN_IN    = 8;

    localparam logic [CAP_W-1:0]         CAP_RESET  = 7'd64;
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic en;         // an item updates the chain this cycle
        logic shr;        // shift toward the rear, new word enters cell 0
        logic shl;        // shift toward the front
        logic push_rear;  // write the word into the first free cell
    } t_cell_ctl;

    // Number of registered OR levels needed to reduce depth leaves
    function automatic int tree_levels(input int depth);
        int lv;
        int span;
        lv   = 1;
        span = FAN_IN;
        while (span < depth) begin
            span = span * FAN_IN;
            lv   = lv + 1;
        end
        return lv;
    endfunction

    // Leaf count padded to a full tree
    function automatic int tree_span(input int depth);
        int span;
        int lv;
        span = 1;
        for (lv = 0; lv < tree_levels(depth); lv++) begin
            span = span * FAN_IN;
        end
        return span;
    endfunction

endpackage

// File: src/bde_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine request channel
// Valid/ready channel that carries one deque request item.
// ----------------------------------------------------------------------------
interface bde_req_if;
    logic                                valid;
    logic                                ready;
    logic [bde_pkg::MODE_W-1:0]          mode;
    logic signed [bde_pkg::WORD_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: src/bde_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine response channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
interface bde_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [bde_pkg::WORD_W-1:0]   front_value;
    logic signed [bde_pkg::WORD_W-1:0]   rear_value;
    logic                                is_empty;
    logic                                is_full;
    logic [bde_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, output occupancy, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, input occupancy, output ready);
endinterface

// File: src/bde_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine cell
// Holds one deque entry; shifts with its neighbors and marks the rear entry.
// ----------------------------------------------------------------------------
module bde_cell #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bde_pkg::t_cell_ctl                          i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]                  i_count,
    input  logic [$clog2(DEPTH+1)-1:0]                  i_count_nxt,
    input  logic signed [bde_pkg::WORD_W-1:0]           i_value,
    input  logic signed [bde_pkg::WORD_W-1:0]           i_left,
    input  logic signed [bde_pkg::WORD_W-1:0]           i_right,
    output logic signed [bde_pkg::WORD_W-1:0]           o_data,
    output logic signed [bde_pkg::WORD_W-1:0]           o_tap
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [bde_pkg::WORD_W-1:0] r_data;
    logic signed [bde_pkg::WORD_W-1:0] n_data;
    logic                              r_mark;

    // Pick the word this cell holds after the item
    always_comb begin
        n_data = r_data;
        if (i_ctl.shr) begin
            n_data = i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end else if (i_ctl.push_rear && (i_count == CW'(IDX))) begin
            n_data = i_value;
        end
    end

    // Advance the entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_data <= n_data;
        end
    end

    // Track whether this cell holds the rear entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else if (i_ctl.en) begin
            r_mark <= (i_count_nxt == CW'(IDX + 1));
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_mark ? r_data : '0;

endmodule

// File: src/bde_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine rear-select tree
// Registered OR tree, eight inputs per node, over the one-hot cell taps.
// ----------------------------------------------------------------------------
module bde_tree #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic signed [bde_pkg::WORD_W-1:0]   i_leaf [DEPTH],
    output logic signed [bde_pkg::WORD_W-1:0]   o_sum
);

    localparam int LVLS = bde_pkg::tree_levels(DEPTH);
    localparam int SPAN = bde_pkg::tree_span(DEPTH);
    localparam int FAN  = bde_pkg::FAN_IN;

    logic signed [bde_pkg::WORD_W-1:0] w_lvl  [LVLS+1][SPAN];
    logic signed [bde_pkg::WORD_W-1:0] r_node [LVLS][SPAN];

    // Pad the leaves out to a full tree
    for (genvar g = 0; g < SPAN; g++) begin : g_leaf
        if (g < DEPTH) begin : g_used
            assign w_lvl[0][g] = i_leaf[g];
        end else begin : g_pad
            assign w_lvl[0][g] = '0;
        end
    end

    // One registered level per pass, eight inputs per node
    for (genvar k = 0; k < LVLS; k++) begin : g_level
        localparam int NODES = SPAN / (FAN ** (k + 1));
        for (genvar j = 0; j < NODES; j++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_node[k][j] <= w_lvl[k][FAN*j]   | w_lvl[k][FAN*j+1] |
                                w_lvl[k][FAN*j+2] | w_lvl[k][FAN*j+3] |
                                w_lvl[k][FAN*j+4] | w_lvl[k][FAN*j+5] |
                                w_lvl[k][FAN*j+6] | w_lvl[k][FAN*j+7];
            end
            assign w_lvl[k+1][j] = r_node[k][j];
        end
    end

    assign o_sum = w_lvl[LVLS][0];

endmodule

// File: src/bounded_deque_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine core
// Double-ended queue of signed words held in a shifting chain of cells.
//
//   channel   dir  handshake            payload
//   i_req     in   valid / ready        mode, value
//   o_rsp     out  valid / ready        ok, front_value, rear_value,
//                                       is_empty, is_full, occupancy
//   i_cfg_*   in   write enable only    capacity
//
// One item is in work at a time. After acceptance its result passes through
// the registered OR tree that fetches the rear entry, eight inputs per node,
// and then reaches the output register. The next item is taken once the
// result is loaded and the sequencer is back in S_IDLE; a full output
// register that is not taken holds the item in S_DONE.
// The output register lets the next item enter while a result waits.
// Reset (synchronous, active low) empties the deque and sets capacity to 64.
// ----------------------------------------------------------------------------
module bounded_deque_engine_core #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bde_pkg::CAP_W-1:0]    i_cfg_wdata,
    bde_req_if.sink                      i_req,
    bde_rsp_if.source                    o_rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KW   = (CW > bde_pkg::CAP_W) ? CW : bde_pkg::CAP_W;
    localparam int LVLS = bde_pkg::tree_levels(DEPTH);
    localparam int SW   = $clog2(LVLS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [SW-1:0]                       r_stage;
    logic [bde_pkg::CAP_W-1:0]           r_cap;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    bde_pkg::t_cell_ctl                  w_ctl;
    logic                                n_ok;
    logic                                w_acc;
    logic                                w_load;
    logic [KW-1:0]                       w_cap_eff;
    logic                                w_room;
    logic                                w_any;

    // Result flags captured at acceptance
    logic                                r_ok;
    logic                                r_empty;
    logic                                r_full;
    logic [bde_pkg::OCC_W-1:0]           r_occ;

    // Output register
    logic                                r_out_vld;
    logic                                r_out_ok;
    logic signed [bde_pkg::WORD_W-1:0]   r_out_front;
    logic signed [bde_pkg::WORD_W-1:0]   r_out_rear;
    logic                                r_out_empty;
    logic                                r_out_full;
    logic [bde_pkg::OCC_W-1:0]           r_out_occ;

    logic signed [bde_pkg::WORD_W-1:0]   w_data [DEPTH];
    logic signed [bde_pkg::WORD_W-1:0]   w_tap  [DEPTH];
    logic signed [bde_pkg::WORD_W-1:0]   w_rear;

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bde_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid & i_req.ready;
    assign w_cap_eff   = (KW'(r_cap) > KW'(DEPTH)) ? KW'(DEPTH) : KW'(r_cap);
    assign w_room      = (KW'(r_count) < w_cap_eff);
    assign w_any       = (r_count != '0);

    // Decode the request into chain control and the new count
    always_comb begin
        w_ctl     = '0;
        w_ctl.en  = w_acc;
        n_ok      = 1'b0;
        n_count   = r_count;
        unique case (i_req.mode)
            bde_pkg::MODE_PUSH_FRONT: begin
                if (w_room) begin
                    w_ctl.shr = w_acc;
                    n_ok      = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            bde_pkg::MODE_PUSH_REAR: begin
                if (w_room) begin
                    w_ctl.push_rear = w_acc;
                    n_ok            = 1'b1;
                    n_count         = r_count + CW'(1);
                end
            end
            bde_pkg::MODE_POP_FRONT: begin
                if (w_any) begin
                    w_ctl.shl = w_acc;
                    n_ok      = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            bde_pkg::MODE_POP_REAR: begin
                if (w_any) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            bde_pkg::MODE_PEEK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Advance the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // Capture the flags of the item in work
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok    <= n_ok;
            r_empty <= (n_count == '0);
            r_full  <= (KW'(n_count) >= w_cap_eff);
            r_occ   <= bde_pkg::OCC_W'(n_count);
        end
    end

    // Chain of cells, front entry in cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [bde_pkg::WORD_W-1:0] w_left;
        logic signed [bde_pkg::WORD_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        bde_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_count_nxt (n_count),
            .i_value     (i_req.value),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_data      (w_data[i]),
            .o_tap       (w_tap[i])
        );
    end

    // Fetch the rear entry through the registered tree
    bde_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_sum  (w_rear)
    );

    assign w_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // Sequence one item: accept, wait for the tree, hand to the output register
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_stage == SW'(LVLS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_stage <= r_stage + SW'(1);
            end else begin
                r_stage <= '0;
            end
        end
    end

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ok    <= r_ok;
            r_out_front <= r_empty ? bde_pkg::EMPTY_WORD : w_data[0];
            r_out_rear  <= r_empty ? bde_pkg::EMPTY_WORD : w_rear;
            r_out_empty <= r_empty;
            r_out_full  <= r_full;
            r_out_occ   <= r_occ;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;
    assign o_rsp.occupancy   = r_out_occ;

endmodule

// File: src/bde_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine checker
// Port-level assertions on the deque engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_deque_engine_core_defines.svh"

module bde_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic signed [bde_pkg::WORD_W-1:0]   i_front,
    input logic signed [bde_pkg::WORD_W-1:0]   i_rear,
    input logic                                i_empty,
    input logic [bde_pkg::OCC_W-1:0]           i_occ
);

    // An empty result reports no entries and the empty word at both ends
    `BDE_ASSERT_NOW(a_empty_result, i_out_valid && i_empty, (i_occ == '0) && (i_front == bde_pkg::EMPTY_WORD) && (i_rear == bde_pkg::EMPTY_WORD), "empty result with entries or data")

    // A non-empty result reports a nonzero occupancy
    `BDE_ASSERT_NOW(a_occ_nonzero, i_out_valid && !i_empty, i_occ != '0, "non-empty result with zero occupancy")

    // A single entry is both the front and the rear
    `BDE_ASSERT_NOW(a_single_entry, i_out_valid && !i_empty && (i_occ == bde_pkg::OCC_W'(1)), i_front == i_rear, "front and rear differ with one entry")

    // One item in work: no acceptance in the cycle after one
    `BDE_ASSERT_NEXT(a_one_in_work, i_in_valid && i_in_ready, !i_in_ready, "request taken while an item is in work")

endmodule

bind bounded_deque_engine_core bde_chk u_bde_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_front     (o_rsp.front_value),
    .i_rear      (o_rsp.rear_value),
    .i_empty     (o_rsp.is_empty),
    .i_occ       (o_rsp.occupancy)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine testbench
// Sends request items with random gaps and checks every response item, in
// order, against a behavioral ring-buffer deque kept in this module. Covers
// every request code, empty and full ends, capacity zero, saturation above
// the store depth, capacity lowered below occupancy, and a long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int RING_DEPTH    = bde_pkg::DEPTH_DEF;
    localparam int IDX_W         = $clog2(RING_DEPTH);
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 40;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_MAX      = 15;

    localparam logic [bde_pkg::MODE_W-1:0]        MODE_UNDEF_FIRST = 3'd5;
    localparam logic [bde_pkg::MODE_W-1:0]        MODE_UNDEF_LAST  = 3'd7;
    localparam logic [bde_pkg::CAP_W-1:0]         CAP_MAX          = 7'd127;
    localparam logic signed [bde_pkg::WORD_W-1:0] WORD_MIN         = 32'sh8000_0000;
    localparam logic signed [bde_pkg::WORD_W-1:0] WORD_MAX         = 32'sh7fff_ffff;

    typedef struct packed {
        logic                              ok;
        logic signed [bde_pkg::WORD_W-1:0] front_value;
        logic signed [bde_pkg::WORD_W-1:0] rear_value;
        logic                              is_empty;
        logic                              is_full;
        logic [bde_pkg::OCC_W-1:0]         occupancy;
    } t_deque_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [bde_pkg::CAP_W-1:0]   cfg_wdata;

    bde_req_if req_ch ();
    bde_rsp_if rsp_ch ();

    bounded_deque_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Behavioral deque: ring of words, head pointer, entry count, capacity
    logic signed [bde_pkg::WORD_W-1:0] ring_word [RING_DEPTH];
    logic [IDX_W-1:0]                  ring_head  = '0;
    logic [bde_pkg::OCC_W-1:0]         ring_count = '0;
    logic [bde_pkg::CAP_W-1:0]         cap_reg    = bde_pkg::CAP_RESET;

    t_deque_result result_q [$];
    t_deque_result want_res;

    int err_count      = 0;
    int cycle_count    = 0;
    int sender_gap_max = 0;
    int rsp_stall_max  = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_left     = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Apply one request to the deque and return the result it must produce
    function automatic t_deque_result apply_request(
            input logic [bde_pkg::MODE_W-1:0] mode,
            input logic signed [bde_pkg::WORD_W-1:0] word);
        t_deque_result             r;
        logic [bde_pkg::OCC_W-1:0] cap_eff;
        logic [IDX_W-1:0]          tail;
        cap_eff = (cap_reg > RING_DEPTH) ? bde_pkg::OCC_W'(RING_DEPTH) : cap_reg;
        r       = '0;
        case (mode)
            bde_pkg::MODE_PUSH_FRONT: begin
                if (ring_count < cap_eff) begin
                    ring_head            = ring_head - 1'b1;
                    ring_word[ring_head] = word;
                    ring_count           = ring_count + 1'b1;
                    r.ok                 = 1'b1;
                end
            end
            bde_pkg::MODE_PUSH_REAR: begin
                if (ring_count < cap_eff) begin
                    tail            = ring_head + IDX_W'(ring_count);
                    ring_word[tail] = word;
                    ring_count      = ring_count + 1'b1;
                    r.ok            = 1'b1;
                end
            end
            bde_pkg::MODE_POP_FRONT: begin
                if (ring_count != 0) begin
                    ring_head  = ring_head + 1'b1;
                    ring_count = ring_count - 1'b1;
                    r.ok       = 1'b1;
                end
            end
            bde_pkg::MODE_POP_REAR: begin
                if (ring_count != 0) begin
                    ring_count = ring_count - 1'b1;
                    r.ok       = 1'b1;
                end
            end
            bde_pkg::MODE_PEEK: r.ok = 1'b1;
            default:            r.ok = 1'b0;
        endcase
        // Report both ends, or the empty marker
        if (ring_count != 0) begin
            tail          = ring_head + IDX_W'(ring_count - 1'b1);
            r.front_value = ring_word[ring_head];
            r.rear_value  = ring_word[tail];
        end else begin
            r.front_value = bde_pkg::EMPTY_WORD;
            r.rear_value  = bde_pkg::EMPTY_WORD;
        end
        r.is_empty  = (ring_count == 0);
        r.is_full   = (ring_count >= cap_eff);
        r.occupancy = ring_count;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [bde_pkg::WORD_W-1:0] want,
                               input logic [bde_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Output side: drive ready with random stalls and long holds, check each item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (hold_reqs != hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_reqs;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (result_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: response item with no request waiting", $time);
                end else begin
                    want_res = result_q.pop_front();
                    check_field("ok", bde_pkg::WORD_W'(want_res.ok),
                                bde_pkg::WORD_W'(rsp_ch.ok));
                    check_field("front_value", want_res.front_value, rsp_ch.front_value);
                    check_field("rear_value", want_res.rear_value, rsp_ch.rear_value);
                    check_field("is_empty", bde_pkg::WORD_W'(want_res.is_empty),
                                bde_pkg::WORD_W'(rsp_ch.is_empty));
                    check_field("is_full", bde_pkg::WORD_W'(want_res.is_full),
                                bde_pkg::WORD_W'(rsp_ch.is_full));
                    check_field("occupancy", bde_pkg::WORD_W'(want_res.occupancy),
                                bde_pkg::WORD_W'(rsp_ch.occupancy));
                end
                stall_left = (rsp_stall_max == 0) ? 0 : $urandom_range(rsp_stall_max, 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one item after a random gap, hold it until accepted, then predict
    task automatic send_item(input logic [bde_pkg::MODE_W-1:0] mode,
                             input logic signed [bde_pkg::WORD_W-1:0] word);
        int gap;
        gap = (sender_gap_max == 0) ? 0 : $urandom_range(sender_gap_max, 0);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.value <= word;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        result_q = {result_q, apply_request(mode, word)};
    endtask

    // Drop valid and wait until every response item is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [bde_pkg::CAP_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cap_reg    = cap;
    endtask

    function automatic logic signed [bde_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(15, 0))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return bde_pkg::EMPTY_WORD;
            default: return $urandom;
        endcase
    endfunction

    // Pick a request: pushes up to push_pct percent, then pops, peeks, bad codes
    task automatic send_random(input int push_pct);
        int                         pick;
        logic [bde_pkg::MODE_W-1:0] mode;
        pick = $urandom_range(99, 0);
        if (pick < push_pct)
            mode = $urandom_range(1, 0) ? bde_pkg::MODE_PUSH_REAR : bde_pkg::MODE_PUSH_FRONT;
        else if (pick < 95)
            mode = $urandom_range(1, 0) ? bde_pkg::MODE_POP_REAR : bde_pkg::MODE_POP_FRONT;
        else if (pick < 98)
            mode = bde_pkg::MODE_PEEK;
        else
            mode = bde_pkg::MODE_W'($urandom_range(MODE_UNDEF_LAST, MODE_UNDEF_FIRST));
        send_item(mode, random_word());
    endtask

    task automatic random_run(input logic [bde_pkg::CAP_W-1:0] cap, input int n_items,
                              input int push_pct, input int gap_max, input int stall_max);
        set_capacity(cap);
        sender_gap_max = gap_max;
        rsp_stall_max  = stall_max;
        repeat (n_items) send_random(push_pct);
    endtask

    // Every request code on an empty and a small deque, at reset capacity
    task automatic test_request_codes();
        int k;
        sender_gap_max = 0;
        rsp_stall_max  = 0;
        send_item(bde_pkg::MODE_PEEK, '0);
        send_item(bde_pkg::MODE_POP_FRONT, WORD_MAX);
        send_item(bde_pkg::MODE_POP_REAR, WORD_MIN);
        send_item(bde_pkg::MODE_PUSH_FRONT, WORD_MAX);
        send_item(bde_pkg::MODE_PUSH_REAR, WORD_MIN);
        send_item(bde_pkg::MODE_PUSH_FRONT, '0);
        send_item(bde_pkg::MODE_PUSH_REAR, bde_pkg::EMPTY_WORD);
        send_item(bde_pkg::MODE_PEEK, 32'sh5a5a_a5a5);
        for (k = MODE_UNDEF_FIRST; k <= MODE_UNDEF_LAST; k++)
            send_item(bde_pkg::MODE_W'(k), bde_pkg::EMPTY_WORD);
        send_item(bde_pkg::MODE_POP_FRONT, '0);
        send_item(bde_pkg::MODE_POP_REAR, '0);
        send_item(bde_pkg::MODE_POP_REAR, '0);
        send_item(bde_pkg::MODE_POP_FRONT, '0);
        send_item(bde_pkg::MODE_POP_FRONT, '0);
    endtask

    // Capacity zero, capacity one, and capacity lowered below occupancy
    task automatic test_capacity_corners();
        sender_gap_max = IDLE_MAX;
        rsp_stall_max  = IDLE_MAX;
        set_capacity('0);
        send_item(bde_pkg::MODE_PUSH_FRONT, 32'sh1234_5678);
        send_item(bde_pkg::MODE_PUSH_REAR, 32'sh0bad_f00d);
        send_item(bde_pkg::MODE_PEEK, '0);
        set_capacity(7'd1);
        send_item(bde_pkg::MODE_PUSH_REAR, 32'sh0000_0001);
        send_item(bde_pkg::MODE_PUSH_FRONT, 32'sh0000_0002);
        send_item(bde_pkg::MODE_POP_REAR, '0);
        set_capacity(7'd4);
        send_item(bde_pkg::MODE_PUSH_FRONT, 32'sh1111_1111);
        send_item(bde_pkg::MODE_PUSH_REAR, 32'sh2222_2222);
        send_item(bde_pkg::MODE_PUSH_FRONT, 32'sh3333_3333);
        send_item(bde_pkg::MODE_PUSH_REAR, 32'sh4444_4444);
        set_capacity(7'd2);
        send_item(bde_pkg::MODE_PUSH_REAR, 32'sh5555_5555);
        send_item(bde_pkg::MODE_PEEK, '0);
        send_item(bde_pkg::MODE_POP_FRONT, '0);
        send_item(bde_pkg::MODE_POP_REAR, '0);
        send_item(bde_pkg::MODE_POP_FRONT, '0);
        send_item(bde_pkg::MODE_POP_REAR, '0);
    endtask

    // Hold the output off while items keep coming, so the input stalls
    task automatic test_output_hold();
        set_capacity(CAP_MAX);
        sender_gap_max = 0;
        rsp_stall_max  = 0;
        hold_reqs++;
        repeat (40) send_random(60);
    endtask

    // Random traffic over a spread of capacities and idle patterns
    task automatic test_random_traffic();
        random_run(bde_pkg::CAP_RESET, 200, 55, IDLE_MAX, IDLE_MAX);
        random_run(CAP_MAX, 200, 75, 0, 0);
        random_run(7'd1, 80, 50, IDLE_MAX, 0);
        random_run('0, 40, 50, 0, IDLE_MAX);
        random_run(7'd3, 100, 55, 0, 0);
        random_run(7'd63, 200, 70, IDLE_MAX, IDLE_MAX);
        random_run(7'd65, 150, 70, 0, IDLE_MAX);
        random_run(7'd5, 120, 40, IDLE_MAX, 0);
        random_run(CAP_MAX, 150, 60, 0, 0);
        random_run(bde_pkg::CAP_W'($urandom_range(CAP_MAX, 0)), 120, 55, IDLE_MAX, IDLE_MAX);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= bde_pkg::MODE_PEEK;
        req_ch.value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_request_codes();
        test_capacity_corners();
        test_output_hold();
        test_random_traffic();

        drain_results();
        if (err_count == 0 && result_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
